>>> rtl/ntsq_pkg.sv
// ----------------------------------------------------------------------------
// ntsq_pkg: shared definitions for the note transpose / scale quantize core
// register indexes, slot kinds, per-slot derived settings, divide-by-12 and
// scale snap helpers
// ----------------------------------------------------------------------------
`default_nettype none

package ntsq_pkg;

  localparam int NOTE_W         = 7;
  localparam int CFG_INDEX_W    = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int SLOT_COUNT_DEF = 4;
  // slots that have bits in the packed registers
  localparam int REG_SLOTS      = 4;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ACTIVE_SLOTS   = 3'd0,
    REG_SLOT_KINDS     = 3'd1,
    REG_SLOT_SEMITONES = 3'd2,
    REG_SLOT_OCTAVES   = 3'd3,
    REG_SLOT_ROOTS     = 3'd4,
    REG_SLOT_MINOR     = 3'd5
  } reg_index_t;

  typedef enum logic [1:0] {
    KIND_PITCH = 2'd0,
    KIND_KEY   = 2'd1,
    KIND_ARP   = 2'd2
  } slot_kind_t;

  // per-slot settings, semitone offset already split as 12*sq + sr
  typedef struct packed {
    logic              enable;
    logic [1:0]        kind;
    logic signed [5:0] sq;
    logic [3:0]        sr;
    logic signed [3:0] oct;
    logic [3:0]        root;
    logic              minor;
  } slot_cfg_t;

  // floor(x / 12) by reciprocal, exact for x below 384
  function automatic logic [4:0] div12(input logic [8:0] x);
    logic [16:0] p;
    p = 17'(x) * 17'd171;
    return p[15:11];
  endfunction

  // step that moves a pitch class to its nearest scale degree
  function automatic logic signed [1:0] snap_move(input logic [3:0] pc, input logic minor);
    logic signed [1:0] mv;
    mv = 2'sd0;
    case ({minor, pc})
      5'h01, 5'h03, 5'h06, 5'h08, 5'h0a: mv = -2'sd1;
      5'h11, 5'h14, 5'h16, 5'h19:        mv = -2'sd1;
      5'h1b:                             mv = 2'sd1;
      default:                           mv = 2'sd0;
    endcase
    return mv;
  endfunction

endpackage

`default_nettype wire

>>> rtl/ntsq_ifs.sv
// ----------------------------------------------------------------------------
// ntsq_ifs: note channels
// valid/ready channels for incoming notes and modified notes
// ----------------------------------------------------------------------------
`default_nettype none

interface ntsq_in_if;
  logic                        valid;
  logic                        ready;
  logic [ntsq_pkg::NOTE_W-1:0] note_in;
  modport source (output valid, output note_in, input ready);
  modport sink   (input valid, input note_in, output ready);
endinterface

interface ntsq_out_if;
  logic                        valid;
  logic                        ready;
  logic [ntsq_pkg::NOTE_W-1:0] note_out;
  modport source (output valid, output note_out, input ready);
  modport sink   (input valid, input note_out, output ready);
endinterface

`default_nettype wire

>>> rtl/ntsq_split.sv
// ----------------------------------------------------------------------------
// ntsq_split: input stage
// takes a note and registers it as octave count and pitch class
// ----------------------------------------------------------------------------
`default_nettype none

module ntsq_split #(
  parameter int Q_W = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  ntsq_in_if.sink                    notes,
  input  wire logic                  dn_ready,
  output logic                       vld,
  output logic signed [Q_W-1:0]      q,
  output logic [3:0]                 r
);

  logic [8:0] x;
  logic [4:0] q5;
  logic [8:0] r9;

  always_comb begin
    x  = 9'(notes.note_in);
    q5 = ntsq_pkg::div12(x);
    r9 = x - 9'(q5) * 9'd12;
  end

  assign notes.ready = !vld || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (notes.ready) begin
      vld <= notes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (notes.ready) begin
      q <= Q_W'(q5);
      r <= r9[3:0];
    end
  end

endmodule

`default_nettype wire

>>> rtl/ntsq_slot.sv
// ----------------------------------------------------------------------------
// ntsq_slot: one modifier slot stage
// pitch shift, key snap or pass-through on an octave/pitch-class value
// ----------------------------------------------------------------------------
`default_nettype none

module ntsq_slot #(
  parameter int Q_W = 8
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire ntsq_pkg::slot_cfg_t     cfg,
  input  wire logic                    up_valid,
  input  wire logic signed [Q_W-1:0]   up_q,
  input  wire logic [3:0]              up_r,
  output logic                         up_ready,
  input  wire logic                    dn_ready,
  output logic                         vld,
  output logic signed [Q_W-1:0]        q,
  output logic [3:0]                   r
);

  logic [4:0]            r_sum;
  logic                  carry;
  logic [3:0]            r_p;
  logic signed [Q_W-1:0] q_p;
  logic signed [5:0]     d0;
  logic signed [5:0]     d1;
  logic signed [5:0]     d2;
  logic signed [1:0]     mv;
  logic [3:0]            r_k;
  logic signed [Q_W-1:0] q_k;
  logic [3:0]            r_next;
  logic signed [Q_W-1:0] q_next;

  always_comb begin
    // pitch shift: add 12*(sq + oct) + sr, fold the pitch class back below 12
    r_sum = 5'(up_r) + 5'(cfg.sr);
    carry = (r_sum >= 5'd12);
    r_p   = carry ? 4'(r_sum - 5'd12) : r_sum[3:0];
    q_p   = up_q + Q_W'(cfg.sq) + Q_W'(cfg.oct) + Q_W'(carry);

    // key snap: pitch class relative to the root, then one step at most
    d0 = 6'(up_r) - 6'(cfg.root);
    d1 = d0[5] ? d0 + 6'sd12 : d0;
    d2 = d1[5] ? d1 + 6'sd12 : d1;
    mv = ntsq_pkg::snap_move(d2[3:0], cfg.minor);
    r_k = up_r;
    q_k = up_q;
    if (mv < 0) begin
      if (up_r == 4'd0) begin
        r_k = 4'd11;
        q_k = up_q - Q_W'(1);
      end else begin
        r_k = up_r - 4'd1;
      end
    end else if (mv > 0) begin
      if (up_r == 4'd11) begin
        r_k = 4'd0;
        q_k = up_q + Q_W'(1);
      end else begin
        r_k = up_r + 4'd1;
      end
    end

    r_next = up_r;
    q_next = up_q;
    if (cfg.enable) begin
      case (cfg.kind)
        ntsq_pkg::KIND_PITCH: begin
          r_next = r_p;
          q_next = q_p;
        end
        ntsq_pkg::KIND_KEY: begin
          r_next = r_k;
          q_next = q_k;
        end
        default: begin
          r_next = up_r;
          q_next = up_q;
        end
      endcase
    end
  end

  assign up_ready = !vld || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (up_ready) begin
      vld <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      q <= q_next;
      r <= r_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ntsq_out.sv
// ----------------------------------------------------------------------------
// ntsq_out: output stage
// clamps the running value to the note range and holds the result register
// ----------------------------------------------------------------------------
`default_nettype none

module ntsq_out #(
  parameter int Q_W = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  up_valid,
  input  wire logic signed [Q_W-1:0] up_q,
  input  wire logic [3:0]            up_r,
  output logic                       up_ready,
  ntsq_out_if.source                 results
);

  logic [ntsq_pkg::NOTE_W-1:0] note_next;

  always_comb begin
    if (up_q[Q_W-1]) begin
      note_next = '0;
    end else if (up_q > Q_W'(10) || (up_q == Q_W'(10) && up_r > 4'd7)) begin
      note_next = '1;
    end else begin
      note_next = 7'(7'(up_q[3:0]) * 7'd12) + 7'(up_r);
    end
  end

  assign up_ready = !results.valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (up_ready) begin
      results.valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      results.note_out <= note_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/note_transpose_scale_quantize_core.sv
// ----------------------------------------------------------------------------
// note_transpose_scale_quantize_core: MIDI note modifier chain
// path from input transfer to result valid: the split stage loads on the
// transfer edge, then the note passes one stage per slot and the
// clamp/output stage
// throughput: one note per cycle; each stage only holds when its successor
// is full, so bubbles are squeezed out while the output waits
// reset (synchronous, rst high) clears the stage valid bits, the config
// registers and the per-slot settings; note data registers are not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module note_transpose_scale_quantize_core #(
  parameter int SLOT_COUNT = ntsq_pkg::SLOT_COUNT_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  ntsq_in_if.sink                               notes,
  ntsq_out_if.source                            results,
  input  wire logic                             cfg_write,
  input  wire logic [ntsq_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [ntsq_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // running value is kept as 12*q + r, r being the pitch class 0..11;
  // each slot moves q by at most 20, so q stays within +/-(10 + 20*slots)
  localparam int Q_W = $clog2(10 + 20 * SLOT_COUNT + 1) + 1;

  // configuration registers
  logic [2:0]  active_slots;
  logic [7:0]  slot_kinds;
  logic [31:0] slot_semitones;
  logic [15:0] slot_octaves;
  logic [15:0] slot_roots;
  logic [3:0]  slot_minor;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_slots   <= '0;
      slot_kinds     <= '0;
      slot_semitones <= '0;
      slot_octaves   <= '0;
      slot_roots     <= '0;
      slot_minor     <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        ntsq_pkg::REG_ACTIVE_SLOTS:   active_slots   <= cfg_data[2:0];
        ntsq_pkg::REG_SLOT_KINDS:     slot_kinds     <= cfg_data[7:0];
        ntsq_pkg::REG_SLOT_SEMITONES: slot_semitones <= cfg_data[31:0];
        ntsq_pkg::REG_SLOT_OCTAVES:   slot_octaves   <= cfg_data[15:0];
        ntsq_pkg::REG_SLOT_ROOTS:     slot_roots     <= cfg_data[15:0];
        ntsq_pkg::REG_SLOT_MINOR:     slot_minor     <= cfg_data[3:0];
        default: begin
          // unmapped index, write dropped
        end
      endcase
    end
  end

  // per-slot settings follow the config registers in the next cycle, through a register;
  // the semitone split costs a small multiply that stays out of the data path
  ntsq_pkg::slot_cfg_t slot_cfg      [SLOT_COUNT];
  ntsq_pkg::slot_cfg_t slot_cfg_next [SLOT_COUNT];

  for (genvar m = 0; m < SLOT_COUNT; m++) begin : g_cfg
    if (m < ntsq_pkg::REG_SLOTS) begin : g_mapped
      logic signed [7:0] semi;
      logic [8:0]        x;
      logic [4:0]        q5;
      logic [8:0]        r9;

      always_comb begin
        semi = slot_semitones[8*m +: 8];
        // offset by 132 = 12*11 so the split works on a positive value
        x    = 9'(semi) + 9'd132;
        q5   = ntsq_pkg::div12(x);
        r9   = x - 9'(q5) * 9'd12;
        slot_cfg_next[m].enable = (32'(active_slots) > m);
        slot_cfg_next[m].kind   = slot_kinds[2*m +: 2];
        slot_cfg_next[m].sq     = 6'(q5) - 6'd11;
        slot_cfg_next[m].sr     = r9[3:0];
        slot_cfg_next[m].oct    = slot_octaves[4*m +: 4];
        slot_cfg_next[m].root   = slot_roots[4*m +: 4];
        slot_cfg_next[m].minor  = slot_minor[m];
      end
    end else begin : g_unmapped
      // no register bits: acts as a pitch shift by zero
      always_comb begin
        slot_cfg_next[m]        = '0;
        slot_cfg_next[m].enable = (32'(active_slots) > m);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        slot_cfg[m] <= '0;
      end else begin
        slot_cfg[m] <= slot_cfg_next[m];
      end
    end
  end

  // stage k = 0 is the split stage, stage k = m + 1 is slot m
  logic                  stg_vld [SLOT_COUNT+1];
  logic signed [Q_W-1:0] stg_q   [SLOT_COUNT+1];
  logic [3:0]            stg_r   [SLOT_COUNT+1];
  // ready offered to stage k by whatever takes its transfer
  logic                  dn_rdy  [SLOT_COUNT+1];

  ntsq_split #(
    .Q_W (Q_W)
  ) u_split (
    .clk      (clk),
    .rst      (rst),
    .notes    (notes),
    .dn_ready (dn_rdy[0]),
    .vld      (stg_vld[0]),
    .q        (stg_q[0]),
    .r        (stg_r[0])
  );

  for (genvar m = 0; m < SLOT_COUNT; m++) begin : g_slot
    ntsq_slot #(
      .Q_W (Q_W)
    ) u_slot (
      .clk      (clk),
      .rst      (rst),
      .cfg      (slot_cfg[m]),
      .up_valid (stg_vld[m]),
      .up_q     (stg_q[m]),
      .up_r     (stg_r[m]),
      .up_ready (dn_rdy[m]),
      .dn_ready (dn_rdy[m+1]),
      .vld      (stg_vld[m+1]),
      .q        (stg_q[m+1]),
      .r        (stg_r[m+1])
    );
  end

  // clamp to 0..127 and hold the result
  ntsq_out #(
    .Q_W (Q_W)
  ) u_out (
    .clk      (clk),
    .rst      (rst),
    .up_valid (stg_vld[SLOT_COUNT]),
    .up_q     (stg_q[SLOT_COUNT]),
    .up_r     (stg_r[SLOT_COUNT]),
    .up_ready (dn_rdy[SLOT_COUNT]),
    .results  (results)
  );

  // an empty output register means nothing can hold up the input
  a_ready_when_out_empty: assert property (
    @(posedge clk) disable iff (rst) !results.valid |-> notes.ready
  ) else $error("input not ready while output register is empty");

  // the split stage must leave a pitch class below twelve
  a_split_pc_range: assert property (
    @(posedge clk) disable iff (rst) stg_vld[0] |-> (stg_r[0] < 4'd12)
  ) else $error("split stage pitch class out of range");

  // every slot stage must keep the pitch class below twelve
  for (genvar k = 1; k <= SLOT_COUNT; k++) begin : g_chk
    a_slot_pc_range: assert property (
      @(posedge clk) disable iff (rst) stg_vld[k] |-> (stg_r[k] < 4'd12)
    ) else $error("slot stage pitch class out of range");
  end

endmodule

`default_nettype wire
